>>> sv/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table package
// Field widths, request and status codes, and the control bundle that the
// controller broadcasts to the row of slot cells.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int OP_W   = 2;
	localparam int KEY_W  = 31;
	localparam int ST_W   = 2;
	localparam int SLOT_W = 4;

	// Request kinds.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

	// Control broadcast to every slot cell.
	typedef struct packed {
		logic             start; // load the probe token at the home slot
		logic             run;   // a probe step takes place this cycle
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

>>> sv/lpht_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Home slot unit
// Works out key modulo TABLE_SLOTS by reciprocal multiplication, then a
// subtract and one final correction, and pulses done when the remainder is
// ready.
// ----------------------------------------------------------------------------
module lpht_mod #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lpht_pkg::KEY_W-1:0]       key,
	output logic                             done,
	output logic [$clog2(TABLE_SLOTS)-1:0]   home
);
	import lpht_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int SH = KEY_W + 1;
	localparam int PW = KEY_W + SH;
	localparam logic [SH-1:0]    RECIP_C = SH'((64'd1 << SH) / 64'(TABLE_SLOTS));
	localparam logic [KEY_W-1:0] DIV_C   = KEY_W'(TABLE_SLOTS);
	localparam logic [IW:0]      NUM_C   = (IW+1)'(TABLE_SLOTS);

	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic [KEY_W-1:0]  key_s1;
	logic [KEY_W-1:0]  key_s2;
	logic [KEY_W-1:0]  quo_s2;
	logic [IW:0]       rem_s3;
	logic [PW-1:0]     prod;
	logic [KEY_W-1:0]  diff;

	// The estimated quotient is the true one or one below it, because the
	// reciprocal is rounded down by less than one part in 2^SH. The first
	// remainder therefore lies below twice TABLE_SLOTS.
	always_comb begin
		prod = PW'(key_s1) * PW'(RECIP_C);
		diff = key_s2 - quo_s2 * DIV_C;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Key, quotient estimate and first remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		if (v_s1) begin
			key_s2 <= key_s1;
			quo_s2 <= prod[PW-1:SH];
		end
		if (v_s2) begin
			rem_s3 <= diff[IW:0];
		end
	end

	// Final correction: take off one more TABLE_SLOTS where needed.
	assign home = (rem_s3 >= NUM_C) ? IW'(rem_s3 - NUM_C) : rem_s3[IW-1:0];
	assign done = v_s3;

endmodule

>>> sv/lpht_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot cell
// Holds one table slot (key and used bit) and one stage of the probe token
// ring. The cell holding the token checks its slot and updates it on an insert or delete hit.
// ----------------------------------------------------------------------------
module lpht_cell #(
	parameter int TABLE_SLOTS = 16,
	parameter int INDEX       = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lpht_pkg::cell_ctrl_t             ctrl,
	input  logic [$clog2(TABLE_SLOTS)-1:0]   home,
	input  logic                             prev_tok,
	output logic                             tok,
	output logic                             hit
);
	import lpht_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam logic [IW-1:0] IDX_C = IW'(INDEX);

	logic             tok_q;
	logic             used_q;
	logic [KEY_W-1:0] key_q;
	logic             match;

	// Free slot for an insert, a used matching slot otherwise.
	always_comb begin
		match = (ctrl.op == OP_INSERT) ? !used_q : (used_q && (key_q == ctrl.key));
		hit   = ctrl.run && tok_q && match;
	end

	// Token stage and used bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			used_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				tok_q <= (home == IDX_C);
			end else if (ctrl.run) begin
				tok_q <= prev_tok;
			end
			if (hit) begin
				if (ctrl.op == OP_INSERT) begin
					used_q <= 1'b1;
				end else if (ctrl.op == OP_DELETE) begin
					used_q <= 1'b0;
				end
			end
		end
	end

	// Stored key, written on an insert hit.
	always_ff @(posedge clk) begin
		if (hit && (ctrl.op == OP_INSERT)) begin
			key_q <= ctrl.key;
		end
	end

	assign tok = tok_q;

endmodule

>>> sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table
// Open-addressing key table with insert, search and delete requests, built
// as a ring of slot cells through which a probe token moves.
// ----------------------------------------------------------------------------
// A request is taken when in_valid is high and in_stall low; one request is
// worked on at a time and exactly one result follows it. A request is
// captured, passes through the home slot unit (reciprocal multiply,
// subtract, then correct and load the token), is probed over up to N slots
// (N = TABLE_SLOTS, one slot cell per cycle as the token moves round the
// ring) and then hands over its result, which waits while the output register
// holds a stalled result; an unused op code skips the home slot unit and probing.
// The next request is taken as soon as the result has been moved to the
// output register, even while that result is stalled. All used bits are
// cleared by reset, so the table is usable at once.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lpht_pkg::OP_W-1:0]     op,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lpht_pkg::ST_W-1:0]     status,
	output logic [lpht_pkg::SLOT_W-1:0]   slot
);
	import lpht_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_C = IW'(TABLE_SLOTS - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MOD   = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [KEY_W-1:0]       key_q;
	logic [IW-1:0]          pos_q;
	logic [IW-1:0]          cnt_q;
	logic [ST_W-1:0]        res_st_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic                   out_valid_q;
	logic [ST_W-1:0]        status_q;
	logic [SLOT_W-1:0]      slot_q;

	logic                   accept;
	logic                   mod_start;
	logic                   mod_done;
	logic [IW-1:0]          home;
	logic                   hit_any;
	logic                   out_load;
	logic                   known_op;
	cell_ctrl_t             ctrl;
	logic [TABLE_SLOTS-1:0] tok;
	logic [TABLE_SLOTS-1:0] hit;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign known_op  = (op == OP_INSERT) || (op == OP_SEARCH) || (op == OP_DELETE);
	assign mod_start = accept && known_op;
	assign hit_any   = |hit;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// Control broadcast to the slot cells.
	always_comb begin
		ctrl.start = (state_q == S_MOD) && mod_done;
		ctrl.run   = (state_q == S_PROBE);
		ctrl.op    = op_q;
		ctrl.key   = key_q;
	end

	lpht_mod #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.key   (key),
		.done  (mod_done),
		.home  (home)
	);

	// Ring of slot cells; the last cell hands its token back to the first.
	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? (TABLE_SLOTS - 1) : (i - 1);
		lpht_cell #(
			.TABLE_SLOTS(TABLE_SLOTS),
			.INDEX      (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.home    (home),
			.prev_tok(tok[PREV]),
			.tok     (tok[i]),
			.hit     (hit[i])
		);
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= known_op ? S_MOD : S_FIN;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (hit_any || (cnt_q == LAST_C)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields, probe position and pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op;
			key_q      <= key;
			res_st_q   <= ST_MISSING;
			res_slot_q <= '0;
		end
		if (ctrl.start) begin
			pos_q <= home;
			cnt_q <= '0;
		end else if (ctrl.run) begin
			pos_q <= (pos_q == LAST_C) ? '0 : pos_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
			if (hit_any) begin
				res_st_q   <= ST_OK;
				res_slot_q <= SLOT_W'(pos_q);
			end else if (cnt_q == LAST_C) begin
				res_st_q   <= (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
				res_slot_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_st_q;
			slot_q   <= res_slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;

endmodule
